>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker file lfr_chk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, muted while reset is held
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// implication checked on every rising edge, muted while reset is held
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// shared types and constants of the lru frame replacer
// ----------------------------------------------------------------------------
package lfr_pkg;

    // field widths
    localparam int CMD_W = 2;
    localparam int ID_W  = 5;
    localparam int CNT_W = 6;

    // number of distinct frame ids the id field can carry
    localparam int ID_SPAN = 32;

    // defaults
    localparam int              FRAMES_DEF = 32;
    localparam logic [CNT_W-1:0] CAP_RESET = 6'd32;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

endpackage

>>> hdl/lfr_ctrl.sv
// ----------------------------------------------------------------------------
// lfr_ctrl
// sequencer: accept one transaction, execute it, hold the result until taken
// ----------------------------------------------------------------------------
module lfr_ctrl import lfr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t dp_cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and handshake outputs
    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        dp_cmd.capture = 1'b0;
        dp_cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                dp_cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                dp_cmd.execute = 1'b1;
                state_next     = ST_RESP;
            end
            ST_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/lfr_dp.sv
// ----------------------------------------------------------------------------
// lfr_dp
// datapath: ordered cell chain, presence flags, count and result registers
// ----------------------------------------------------------------------------
module lfr_dp import lfr_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  dp_cmd_t          dp_cmd,
    input  logic [CMD_W-1:0] s_cmd,
    input  logic [ID_W-1:0]  s_frame,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    output logic             m_victim_valid,
    output logic [ID_W-1:0]  m_victim_frame,
    output logic [CNT_W-1:0] m_tracked_count
);

    // ids above the id field can never appear, so the chain stops there
    localparam int DEPTH = (FRAMES < ID_SPAN) ? FRAMES : ID_SPAN;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [ID_W-1:0]  cells_reg [DEPTH];
    logic [ID_W-1:0]  cells_next [DEPTH];
    logic [DEPTH-1:0] present_reg, present_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cap_reg;
    logic [CMD_W-1:0] op_reg;
    logic [ID_W-1:0]  frame_reg;
    logic             res_valid_reg, res_valid_next;
    logic [ID_W-1:0]  res_frame_reg, res_frame_next;
    logic [CNT_W-1:0] res_count_reg;

    logic             frame_ok;
    logic [IDX_W-1:0] frame_idx;
    logic [IDX_W-1:0] head_idx;
    logic             hit;
    logic             room;
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] shift_at;
    logic             run_or;

    // operand decode
    assign frame_ok  = {1'b0, frame_reg} < DEPTH_C;
    assign frame_idx = frame_reg[IDX_W-1:0];
    assign head_idx  = cells_reg[0][IDX_W-1:0];
    assign hit       = frame_ok && present_reg[frame_idx];
    assign room      = (count_reg < cap_reg) && (count_reg < DEPTH_C);

    // locate the pinned frame among the live cells, mark it and all cells above
    always_comb begin
        run_or = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            match[i]    = (CNT_W'(i) < count_reg) && (cells_reg[i] == frame_reg);
            run_or      = run_or | match[i];
            shift_at[i] = run_or;
        end
    end

    // next state of the chain, flags and count
    always_comb begin
        cells_next     = cells_reg;
        present_next   = present_reg;
        count_next     = count_reg;
        res_valid_next = 1'b0;
        res_frame_next = '0;
        unique case (op_reg)
            CMD_VICTIM: begin
                if (count_reg != '0) begin
                    res_valid_next          = 1'b1;
                    res_frame_next          = cells_reg[0];
                    present_next[head_idx]  = 1'b0;
                    count_next              = count_reg - 1'b1;
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        cells_next[i] = cells_reg[i+1];
                    end
                end
            end
            CMD_PIN: begin
                if (hit) begin
                    present_next[frame_idx] = 1'b0;
                    if (|match) begin
                        count_next = count_reg - 1'b1;
                    end
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (shift_at[i]) begin
                            cells_next[i] = cells_reg[i+1];
                        end
                    end
                end
            end
            CMD_UNPIN: begin
                if (frame_ok && room && !present_reg[frame_idx]) begin
                    present_next[frame_idx] = 1'b1;
                    count_next              = count_reg + 1'b1;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (count_reg == CNT_W'(i)) begin
                            cells_next[i] = frame_reg;
                        end
                    end
                end
            end
            default: begin
                // unused code: no change
            end
        endcase
    end

    // control state: count, flags, capacity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            present_reg <= '0;
            cap_reg     <= CAP_RESET;
        end else begin
            if (dp_cmd.execute) begin
                count_reg   <= count_next;
                present_reg <= present_next;
            end
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // payload: operand latch, cell chain and result
    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            op_reg    <= s_cmd;
            frame_reg <= s_frame;
        end
        if (dp_cmd.execute) begin
            cells_reg     <= cells_next;
            res_valid_reg <= res_valid_next;
            res_frame_reg <= res_frame_next;
            res_count_reg <= count_next;
        end
    end

    assign m_victim_valid  = res_valid_reg;
    assign m_victim_frame  = res_frame_reg;
    assign m_tracked_count = res_count_reg;

endmodule

>>> hdl/lru_frame_replacer_top.sv
// ----------------------------------------------------------------------------
// lru_frame_replacer_top
// lru replacer of evictable buffer frames: victim, pin and unpin commands
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_cmd, s_frame
//  m_        out        m_valid / m_ready   m_victim_valid, m_victim_frame,
//                                           m_tracked_count
//  cfg_      in         cfg_we (no wait)    cfg_wdata (capacity)
//
//  one transaction at a time: accept, execute, result, in the idle, execute
//  and respond states; a new input is taken only after the result is taken
//  the result is registered in the execute state and shown in the respond state
//  a stalled result holds and s_ready stays low until it is taken
//  reset clears the count and all presence flags at once, no clearing pass
// ----------------------------------------------------------------------------
module lru_frame_replacer_top import lfr_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [CMD_W-1:0] s_cmd,
    input  logic [ID_W-1:0]  s_frame,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_victim_valid,
    output logic [ID_W-1:0]  m_victim_frame,
    output logic [CNT_W-1:0] m_tracked_count
);

    dp_cmd_t dp_cmd;

    // sequencer
    lfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_cmd  (dp_cmd)
    );

    // datapath
    lfr_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .dp_cmd          (dp_cmd),
        .s_cmd           (s_cmd),
        .s_frame         (s_frame),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .m_victim_valid  (m_victim_valid),
        .m_victim_frame  (m_victim_frame),
        .m_tracked_count (m_tracked_count)
    );

endmodule

>>> hdl/lfr_chk.sv
// ----------------------------------------------------------------------------
// lfr_chk
// port level checks of the lru frame replacer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfr_chk import lfr_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_victim_valid,
    input logic [ID_W-1:0]  m_victim_frame,
    input logic [CNT_W-1:0] m_tracked_count
);

    // one transaction in flight: never ready for input while a result waits
    `ASSERT_CLK(a_one_in_flight, aclk, aresetn, !(s_ready && m_valid), "input ready while result pending")

    // an accepted transaction passes through the execute state and then shows its result
    `ASSERT_IMPL(a_result_latency, aclk, aresetn, s_valid && s_ready, ##2 m_valid, "result not presented in time")

    // no eviction reports frame zero
    `ASSERT_IMPL(a_no_victim_zero, aclk, aresetn, m_valid && !m_victim_valid, m_victim_frame == '0, "frame set without eviction")

    // count never exceeds the id space
    `ASSERT_IMPL(a_count_range, aclk, aresetn, m_valid, m_tracked_count <= CNT_W'(ID_SPAN), "tracked count out of range")

    // stalled result holds
    `ASSERT_IMPL(a_stall_hold, aclk, aresetn, m_valid && !m_ready, ##1 (m_valid && $stable(m_tracked_count)), "stalled result changed")

endmodule

bind lru_frame_replacer_top lfr_chk u_lfr_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_victim_valid  (m_victim_valid),
    .m_victim_frame  (m_victim_frame),
    .m_tracked_count (m_tracked_count)
);
